// ----- rtl/tdvt_pkg.sv -----
// ============================================================================
// tdvt_pkg : shared types and helpers for the deletable voxel test
// Direction codes, the mask term bundle and neighbourhood lookup functions.
// ============================================================================
`default_nettype none

package tdvt_pkg;

    localparam int NbhW  = 27;
    localparam int ModeW = 3;
    localparam int CntW  = 4;
    localparam int CenterBit = 13;

    typedef logic [NbhW-1:0] t_nbh;

    typedef enum logic [ModeW-1:0] {
        MODE_UP    = 3'd0,
        MODE_DOWN  = 3'd1,
        MODE_WEST  = 3'd2,
        MODE_EAST  = 3'd3,
        MODE_NORTH = 3'd4,
        MODE_SOUTH = 3'd5
    } t_mode;

    // Partial mask results handed from the match stage to the decision stage.
    typedef struct packed {
        logic empty9;
        logic empty8;
        logic ge6;
        logic ge4;
        logic bot;
        logic m1;
        logic m56;
        logic m4;
        logic m2;
        logic m3;
    } t_terms;

    function automatic logic vb(input t_nbh n, input int x, input int y, input int z);
        return n[x + 3*y + 9*z];
    endfunction

    // Side positions in the x/z plane, used by M2 and M5.
    function automatic int side_x(input int i);
        case (i)
            0: return 0;
            1: return 2;
            default: return 1;
        endcase
    endfunction

    function automatic int side_z(input int i);
        case (i)
            2: return 0;
            3: return 2;
            default: return 1;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tdvt_reorient.sv -----
// ============================================================================
// tdvt_reorient : first pipeline stage
// Clears the centre bit and turns the neighbourhood so the chosen direction
// points up, then registers the result.
// ============================================================================
`default_nettype none

module tdvt_reorient (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire tdvt_pkg::t_nbh i_neighborhood,
    input  wire logic [2:0]     i_mode,
    output logic                o_valid,
    input  wire logic           i_ready,
    output tdvt_pkg::t_nbh      o_nbh
);

    logic           r_valid;
    tdvt_pkg::t_nbh r_nbh;
    tdvt_pkg::t_nbh n_nbh;
    tdvt_pkg::t_nbh w_src;

    always_comb begin
        int dx, dy, dz;
        w_src = i_neighborhood;
        w_src[tdvt_pkg::CenterBit] = 1'b0;
        n_nbh = '0;
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                for (int z = 0; z < 3; z++) begin
                    dx = x;
                    dy = y;
                    dz = z;
                    case (i_mode)
                        tdvt_pkg::MODE_DOWN:  dy = 2 - y;
                        tdvt_pkg::MODE_WEST:  begin dx = 2 - y; dy = x; end
                        tdvt_pkg::MODE_EAST:  begin dx = y; dy = 2 - x; end
                        tdvt_pkg::MODE_NORTH: begin dy = z; dz = 2 - y; end
                        tdvt_pkg::MODE_SOUTH: begin dy = 2 - z; dz = y; end
                        default: ;
                    endcase
                    n_nbh[dx + 3*dy + 9*dz] = w_src[x + 3*y + 9*z];
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_nbh <= n_nbh;
        end
    end

    assign o_valid = r_valid;
    assign o_nbh   = r_nbh;

endmodule

`default_nettype wire

// ----- rtl/tdvt_masks.sv -----
// ============================================================================
// tdvt_masks : second pipeline stage
// Counts the empty voxels of the top plane and matches masks M1 to M6 on the
// upright neighbourhood; the partial results are registered as one bundle.
// ============================================================================
`default_nettype none

module tdvt_masks (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire tdvt_pkg::t_nbh i_nbh,
    output logic                o_valid,
    input  wire logic           i_ready,
    output tdvt_pkg::t_terms    o_terms
);

    logic                      r_valid;
    tdvt_pkg::t_terms          r_terms;
    tdvt_pkg::t_terms          n_terms;
    logic [tdvt_pkg::CntW-1:0] w_empty;

    function automatic logic match_m6(input tdvt_pkg::t_nbh n);
        logic hit;
        hit = 1'b0;
        if (tdvt_pkg::vb(n,1,0,2)) begin
            if (tdvt_pkg::vb(n,0,0,1))
                hit = !tdvt_pkg::vb(n,2,0,0) && !tdvt_pkg::vb(n,2,0,1)
                   && !tdvt_pkg::vb(n,1,0,0) && !tdvt_pkg::vb(n,2,1,0)
                   && !tdvt_pkg::vb(n,2,1,1) && !tdvt_pkg::vb(n,1,1,0);
            else if (tdvt_pkg::vb(n,2,0,1))
                hit = !tdvt_pkg::vb(n,0,0,0) && !tdvt_pkg::vb(n,0,0,1)
                   && !tdvt_pkg::vb(n,1,0,0) && !tdvt_pkg::vb(n,0,1,0)
                   && !tdvt_pkg::vb(n,0,1,1) && !tdvt_pkg::vb(n,1,1,0);
        end else if (tdvt_pkg::vb(n,1,0,0)) begin
            if (tdvt_pkg::vb(n,0,0,1))
                hit = !tdvt_pkg::vb(n,2,0,2) && !tdvt_pkg::vb(n,2,0,1)
                   && !tdvt_pkg::vb(n,1,0,2) && !tdvt_pkg::vb(n,2,1,2)
                   && !tdvt_pkg::vb(n,2,1,1) && !tdvt_pkg::vb(n,1,1,2);
            else if (tdvt_pkg::vb(n,2,0,1))
                hit = !tdvt_pkg::vb(n,0,0,2) && !tdvt_pkg::vb(n,0,0,1)
                   && !tdvt_pkg::vb(n,1,0,2) && !tdvt_pkg::vb(n,0,1,2)
                   && !tdvt_pkg::vb(n,0,1,1) && !tdvt_pkg::vb(n,1,1,2);
        end
        return hit;
    endfunction

    function automatic logic match_m5(input tdvt_pkg::t_nbh n);
        logic hit;
        int   ix, iz, ox, oz;
        hit = 1'b0;
        for (int i = 0; i < 4; i++) begin
            ix = tdvt_pkg::side_x(i);
            iz = tdvt_pkg::side_z(i);
            ox = 2 - ix;
            oz = 2 - iz;
            if (tdvt_pkg::vb(n,ix,0,iz)) begin
                if (ix == 1) begin
                    if (!tdvt_pkg::vb(n,0,0,oz) && !tdvt_pkg::vb(n,1,0,oz)
                        && !tdvt_pkg::vb(n,2,0,oz) && !tdvt_pkg::vb(n,0,1,oz)
                        && !tdvt_pkg::vb(n,1,1,oz) && !tdvt_pkg::vb(n,2,1,oz)
                        && (tdvt_pkg::vb(n,0,1,iz) || tdvt_pkg::vb(n,1,1,iz)
                        || tdvt_pkg::vb(n,2,1,iz) || tdvt_pkg::vb(n,0,1,1)
                        || tdvt_pkg::vb(n,2,1,1) || tdvt_pkg::vb(n,0,0,iz)
                        || tdvt_pkg::vb(n,0,0,1) || tdvt_pkg::vb(n,2,0,iz)
                        || tdvt_pkg::vb(n,2,0,1)))
                        hit = 1'b1;
                end else begin
                    if (!tdvt_pkg::vb(n,ox,0,0) && !tdvt_pkg::vb(n,ox,0,1)
                        && !tdvt_pkg::vb(n,ox,0,2) && !tdvt_pkg::vb(n,ox,1,0)
                        && !tdvt_pkg::vb(n,ox,1,1) && !tdvt_pkg::vb(n,ox,1,2)
                        && (tdvt_pkg::vb(n,ix,1,0) || tdvt_pkg::vb(n,ix,1,1)
                        || tdvt_pkg::vb(n,ix,1,2) || tdvt_pkg::vb(n,1,1,0)
                        || tdvt_pkg::vb(n,1,1,2) || tdvt_pkg::vb(n,ix,0,0)
                        || tdvt_pkg::vb(n,1,0,0) || tdvt_pkg::vb(n,ix,0,2)
                        || tdvt_pkg::vb(n,1,0,2)))
                        hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    function automatic logic match_m1(input tdvt_pkg::t_nbh n);
        logic hit;
        hit = 1'b0;
        for (int x = 0; x < 3; x++)
            for (int j = 0; j < 2; j++)
                for (int z = 0; z < 3; z++)
                    if ((x != 1 || z != 1) && tdvt_pkg::vb(n,x,j,z))
                        hit = 1'b1;
        return hit;
    endfunction

    function automatic logic match_m4(input tdvt_pkg::t_nbh n);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i <= 2; i += 2)
            for (int k = 0; k <= 2; k += 2)
                if (tdvt_pkg::vb(n,i,2,k) && tdvt_pkg::vb(n,i,1,k))
                    hit = 1'b1;
        return hit;
    endfunction

    function automatic logic match_m2(input tdvt_pkg::t_nbh n);
        logic hit;
        int   ix, iz, ox, oz;
        hit = 1'b0;
        for (int i = 0; i < 4; i++) begin
            ix = tdvt_pkg::side_x(i);
            iz = tdvt_pkg::side_z(i);
            ox = 2 - ix;
            oz = 2 - iz;
            if (tdvt_pkg::vb(n,ix,1,iz)) begin
                if (ix == 1) begin
                    if (!tdvt_pkg::vb(n,0,2,oz) && !tdvt_pkg::vb(n,1,2,oz)
                        && !tdvt_pkg::vb(n,2,2,oz) && !tdvt_pkg::vb(n,0,2,1)
                        && !tdvt_pkg::vb(n,1,2,1) && !tdvt_pkg::vb(n,2,2,1))
                        hit = 1'b1;
                end else begin
                    if (!tdvt_pkg::vb(n,ox,2,0) && !tdvt_pkg::vb(n,ox,2,1)
                        && !tdvt_pkg::vb(n,ox,2,2) && !tdvt_pkg::vb(n,1,2,0)
                        && !tdvt_pkg::vb(n,1,2,1) && !tdvt_pkg::vb(n,1,2,2))
                        hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    function automatic logic match_m3(input tdvt_pkg::t_nbh n);
        logic hit;
        hit = 1'b0;
        if (!tdvt_pkg::vb(n,1,2,1)) begin
            if (tdvt_pkg::vb(n,1,1,2)) begin
                if (tdvt_pkg::vb(n,0,1,1))
                    hit = !tdvt_pkg::vb(n,2,2,0) && !tdvt_pkg::vb(n,2,2,1)
                       && !tdvt_pkg::vb(n,1,2,0);
                else if (tdvt_pkg::vb(n,2,1,1))
                    hit = !tdvt_pkg::vb(n,0,2,0) && !tdvt_pkg::vb(n,0,2,1)
                       && !tdvt_pkg::vb(n,1,2,0);
            end else if (tdvt_pkg::vb(n,1,1,0)) begin
                if (tdvt_pkg::vb(n,0,1,1))
                    hit = !tdvt_pkg::vb(n,2,2,2) && !tdvt_pkg::vb(n,2,2,1)
                       && !tdvt_pkg::vb(n,1,2,2);
                else if (tdvt_pkg::vb(n,2,1,1))
                    hit = !tdvt_pkg::vb(n,0,2,2) && !tdvt_pkg::vb(n,0,2,1)
                       && !tdvt_pkg::vb(n,1,2,2);
            end
        end
        return hit;
    endfunction

    always_comb begin
        w_empty = '0;
        for (int x = 0; x < 3; x++)
            for (int z = 0; z < 3; z++)
                if (!tdvt_pkg::vb(i_nbh, x, 2, z))
                    w_empty = w_empty + 4'd1;
    end

    always_comb begin
        n_terms.empty9 = (w_empty == 4'd9);
        n_terms.empty8 = (w_empty == 4'd8);
        n_terms.ge6    = (w_empty >= 4'd6);
        n_terms.ge4    = (w_empty >= 4'd4);
        n_terms.bot    = tdvt_pkg::vb(i_nbh, 1, 0, 1);
        n_terms.m1     = match_m1(i_nbh);
        n_terms.m56    = match_m6(i_nbh) || match_m5(i_nbh);
        n_terms.m4     = match_m4(i_nbh);
        n_terms.m2     = match_m2(i_nbh);
        n_terms.m3     = match_m3(i_nbh);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_valid;
    assign o_terms = r_terms;

endmodule

`default_nettype wire

// ----- rtl/tdvt_decide.sv -----
// ============================================================================
// tdvt_decide : last pipeline stage
// Applies the empty-plane tests to the mask terms and registers the answer
// in the output register.
// ============================================================================
`default_nettype none

module tdvt_decide (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire tdvt_pkg::t_terms i_terms,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_deletable
);

    logic r_valid;
    logic r_del;
    logic n_del;

    // M1 only counts when the bottom centre is set; otherwise M6 and M5 apply.
    always_comb begin
        n_del = (i_terms.empty9 && (i_terms.bot ? i_terms.m1 : i_terms.m56))
             || (i_terms.bot && ((i_terms.empty8 && i_terms.m4)
                              || (i_terms.ge6 && i_terms.m2)
                              || (i_terms.ge4 && i_terms.m3)));
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_del <= n_del;
        end
    end

    assign o_valid     = r_valid;
    assign o_deletable = r_del;

endmodule

`default_nettype wire

// ----- rtl/thinning_deletable_voxel_test_unit.sv -----
// ============================================================================
// thinning_deletable_voxel_test_unit : directional thinning deletability test
// An accepted input beat is registered in each stage in turn to give the result.
// Throughput: one beat per cycle while the output is ready, set by three register
// stages (reorient, mask match, decision), each of which refills as it empties.
// Back-pressure from the output stalls only the stages that hold data.
// Reset: synchronous, active low; clears all stage valid bits, no other state.
// ============================================================================
`default_nettype none

module thinning_deletable_voxel_test_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [26:0] i_neighborhood,
    input  wire logic [2:0]  i_mode,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_deletable
);

    logic             w_a_valid, w_a_ready;
    tdvt_pkg::t_nbh   w_a_nbh;
    logic             w_b_valid, w_b_ready;
    tdvt_pkg::t_terms w_b_terms;

    tdvt_reorient u_reorient (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_neighborhood (i_neighborhood),
        .i_mode         (i_mode),
        .o_valid        (w_a_valid),
        .i_ready        (w_a_ready),
        .o_nbh          (w_a_nbh)
    );

    tdvt_masks u_masks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_a_valid),
        .o_ready (w_a_ready),
        .i_nbh   (w_a_nbh),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready),
        .o_terms (w_b_terms)
    );

    tdvt_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_b_valid),
        .o_ready     (w_b_ready),
        .i_terms     (w_b_terms),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_deletable (o_deletable)
    );

    // The input can only be refused when every stage holds a beat.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (w_a_valid && w_b_valid && o_valid))
        else $error("input refused while a stage is empty");

    // With the output free, the decision stage takes whatever the match stage held.
    a_flow_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |=> (o_valid == $past(w_b_valid)))
        else $error("output valid does not follow the match stage");

    // The empty-plane flags must agree with one another.
    a_count_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_valid && w_b_terms.empty9) |->
            (w_b_terms.ge6 && w_b_terms.ge4 && !w_b_terms.empty8))
        else $error("inconsistent empty-plane flags");

endmodule

`default_nettype wire

// ----- tb/sv/thinning_deletable_voxel_test_unit_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// thinning_deletable_voxel_test_unit_test : deletable voxel test bench
// Streams neighbourhood beats into the unit with random gaps and output
// stalls, and predicts each answer independently. The prediction reorients
// the neighbourhood for the direction and matches masks M1 to M6. A short
// directed run comes first, then random neighbourhoods, mostly shaped, in every
// direction. The last stretch of the run has no idling.
// ============================================================================

module thinning_deletable_voxel_test_unit_test;

    localparam int RandItems   = 450;
    localparam int CalmItems   = 60;
    localparam int DrainCycles = 8;
    localparam int QuietLimit  = 1000;

    class voxel_scoreboard;
        bit             deletable_q[$];
        int             errors;
        tdvt_pkg::t_nbh vox;

        function new();
            errors = 0;
        endfunction

        // Moves the bit at (x,y,z) so that the chosen direction faces up.
        function tdvt_pkg::t_nbh reorient(tdvt_pkg::t_nbh src, logic [2:0] dir);
            tdvt_pkg::t_nbh dst;
            int             x, y, z, dx, dy, dz;
            dst = '0;
            for (x = 0; x < 3; x++) begin
                for (y = 0; y < 3; y++) begin
                    for (z = 0; z < 3; z++) begin
                        if (src[x + 3*y + 9*z]) begin
                            dx = x;
                            dy = y;
                            dz = z;
                            case (dir)
                                tdvt_pkg::MODE_DOWN: dy = 2 - y;
                                tdvt_pkg::MODE_WEST: begin
                                    dx = 2 - y;
                                    dy = x;
                                end
                                tdvt_pkg::MODE_EAST: begin
                                    dx = y;
                                    dy = 2 - x;
                                end
                                tdvt_pkg::MODE_NORTH: begin
                                    dy = z;
                                    dz = 2 - y;
                                end
                                tdvt_pkg::MODE_SOUTH: begin
                                    dy = 2 - z;
                                    dz = y;
                                end
                                default: ;
                            endcase
                            dst[dx + 3*dy + 9*dz] = 1'b1;
                        end
                    end
                end
            end
            return dst;
        endfunction

        function bit occ(int x, int y, int z);
            return vox[x + 3*y + 9*z];
        endfunction

        function bit mask_match();
            int empty_top, i, j, k, x, z, ix, iz, ox, oz;
            int sx[4];
            int sz[4];
            sx = '{0, 2, 1, 1};
            sz = '{1, 1, 0, 2};
            empty_top = 0;
            for (x = 0; x < 3; x++)
                for (z = 0; z < 3; z++)
                    if (!occ(x, 2, z))
                        empty_top++;

            if (empty_top == 9) begin
                if (occ(1, 0, 1)) begin
                    // M1: any further object voxel in the two lower planes.
                    for (x = 0; x < 3; x++)
                        for (j = 0; j < 2; j++)
                            for (z = 0; z < 3; z++)
                                if ((x != 1 || z != 1) && occ(x, j, z))
                                    return 1'b1;
                end else begin
                    // M6: an edge pair in the bottom plane with its far side clear.
                    if (occ(1, 0, 2)) begin
                        if (occ(0, 0, 1)) begin
                            if (!occ(2,0,0) && !occ(2,0,1) && !occ(1,0,0) &&
                                !occ(2,1,0) && !occ(2,1,1) && !occ(1,1,0))
                                return 1'b1;
                        end else if (occ(2, 0, 1)) begin
                            if (!occ(0,0,0) && !occ(0,0,1) && !occ(1,0,0) &&
                                !occ(0,1,0) && !occ(0,1,1) && !occ(1,1,0))
                                return 1'b1;
                        end
                    end else if (occ(1, 0, 0)) begin
                        if (occ(0, 0, 1)) begin
                            if (!occ(2,0,2) && !occ(2,0,1) && !occ(1,0,2) &&
                                !occ(2,1,2) && !occ(2,1,1) && !occ(1,1,2))
                                return 1'b1;
                        end else if (occ(2, 0, 1)) begin
                            if (!occ(0,0,2) && !occ(0,0,1) && !occ(1,0,2) &&
                                !occ(0,1,2) && !occ(0,1,1) && !occ(1,1,2))
                                return 1'b1;
                        end
                    end
                    // M5: a bottom side voxel with the opposite slab clear.
                    for (i = 0; i < 4; i++) begin
                        ix = sx[i];
                        iz = sz[i];
                        if (occ(ix, 0, iz)) begin
                            if (ix == 1) begin
                                oz = 2 - iz;
                                if (!occ(0,0,oz) && !occ(1,0,oz) && !occ(2,0,oz) &&
                                    !occ(0,1,oz) && !occ(1,1,oz) && !occ(2,1,oz))
                                    if (occ(0,1,iz) || occ(1,1,iz) || occ(2,1,iz) ||
                                        occ(0,1,1) || occ(2,1,1) ||
                                        occ(0,0,iz) || occ(0,0,1) ||
                                        occ(2,0,iz) || occ(2,0,1))
                                        return 1'b1;
                            end else begin
                                ox = 2 - ix;
                                if (!occ(ox,0,0) && !occ(ox,0,1) && !occ(ox,0,2) &&
                                    !occ(ox,1,0) && !occ(ox,1,1) && !occ(ox,1,2))
                                    if (occ(ix,1,0) || occ(ix,1,1) || occ(ix,1,2) ||
                                        occ(1,1,0) || occ(1,1,2) ||
                                        occ(ix,0,0) || occ(1,0,0) ||
                                        occ(ix,0,2) || occ(1,0,2))
                                        return 1'b1;
                            end
                        end
                    end
                end
            end

            if (!occ(1, 0, 1))
                return 1'b0;

            // M4: exactly one top corner set, supported from below.
            if (empty_top == 8) begin
                for (i = 0; i <= 2; i += 2)
                    for (k = 0; k <= 2; k += 2)
                        if (occ(i, 2, k) && occ(i, 1, k))
                            return 1'b1;
            end
            if (empty_top >= 6) begin
                for (i = 0; i < 4; i++) begin
                    ix = sx[i];
                    iz = sz[i];
                    if (occ(ix, 1, iz)) begin
                        if (ix == 1) begin
                            oz = 2 - iz;
                            if (!occ(0,2,oz) && !occ(1,2,oz) && !occ(2,2,oz) &&
                                !occ(0,2,1) && !occ(1,2,1) && !occ(2,2,1))
                                return 1'b1;
                        end else begin
                            ox = 2 - ix;
                            if (!occ(ox,2,0) && !occ(ox,2,1) && !occ(ox,2,2) &&
                                !occ(1,2,0) && !occ(1,2,1) && !occ(1,2,2))
                                return 1'b1;
                        end
                    end
                end
            end
            if (empty_top >= 4 && !occ(1, 2, 1)) begin
                if (occ(1, 1, 2)) begin
                    if (occ(0, 1, 1)) begin
                        if (!occ(2,2,0) && !occ(2,2,1) && !occ(1,2,0))
                            return 1'b1;
                    end else if (occ(2, 1, 1)) begin
                        if (!occ(0,2,0) && !occ(0,2,1) && !occ(1,2,0))
                            return 1'b1;
                    end
                end else if (occ(1, 1, 0)) begin
                    if (occ(0, 1, 1)) begin
                        if (!occ(2,2,2) && !occ(2,2,1) && !occ(1,2,2))
                            return 1'b1;
                    end else if (occ(2, 1, 1)) begin
                        if (!occ(0,2,2) && !occ(0,2,1) && !occ(1,2,2))
                            return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_voxel(tdvt_pkg::t_nbh nbh, logic [2:0] dir);
            vox = reorient(nbh & ~(tdvt_pkg::t_nbh'(1) << tdvt_pkg::CenterBit), dir);
            deletable_q.insert(deletable_q.size(), mask_match());
        endfunction

        function void check_deletable(logic got);
            bit want;
            if (deletable_q.size() == 0) begin
                $error("deletable: expected nothing, got %0b", got);
                errors++;
            end else begin
                want = deletable_q.pop_front();
                if (got !== want) begin
                    $error("deletable: expected %0b, got %0b", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return deletable_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [26:0] i_neighborhood;
    logic [2:0]  i_mode;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_deletable;

    voxel_scoreboard sb;
    bit idle_on;
    int stall_left;
    int quiet_cycles;

    thinning_deletable_voxel_test_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_neighborhood (i_neighborhood),
        .i_mode         (i_mode),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_deletable    (o_deletable)
    );

    always #1 i_clk = ~i_clk;

    function automatic tdvt_pkg::t_nbh vox_bit(int x, int y, int z);
        return tdvt_pkg::t_nbh'(1) << (x + 3*y + 9*z);
    endfunction

    // Each direction is undone by its opposite turn; up and down undo themselves.
    function automatic logic [2:0] undo_dir(logic [2:0] dir);
        case (dir)
            tdvt_pkg::MODE_WEST:  return tdvt_pkg::MODE_EAST;
            tdvt_pkg::MODE_EAST:  return tdvt_pkg::MODE_WEST;
            tdvt_pkg::MODE_NORTH: return tdvt_pkg::MODE_SOUTH;
            tdvt_pkg::MODE_SOUTH: return tdvt_pkg::MODE_NORTH;
            default:              return dir;
        endcase
    endfunction

    function automatic logic [2:0] pick_dir();
        if ($urandom_range(0, 15) == 0)
            return 3'($urandom_range(6, 7));
        return 3'($urandom_range(tdvt_pkg::MODE_UP, tdvt_pkg::MODE_SOUTH));
    endfunction

    // Neighbourhood seen from above: a sparse or empty top plane and a bottom
    // centre that is mostly set, so that the mask tests are reached often.
    function automatic tdvt_pkg::t_nbh shaped_voxel();
        tdvt_pkg::t_nbh n;
        int             lower_density, top_density, b;
        n = '0;
        lower_density = $urandom_range(1, 4);
        top_density = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        for (b = 0; b < tdvt_pkg::NbhW; b++) begin
            if ((b / 3) % 3 == 2)
                n[b] = ($urandom_range(0, 7) < top_density);
            else
                n[b] = ($urandom_range(0, 7) < lower_density);
        end
        if ($urandom_range(0, 3) != 0)
            n |= vox_bit(1, 0, 1);
        return n;
    endfunction

    task automatic drive_voxel(input tdvt_pkg::t_nbh nbh, input logic [2:0] dir);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_neighborhood <= nbh;
        i_mode <= dir;
        do @(posedge i_clk); while (!o_ready);
        sb.note_voxel(nbh, dir);
    endtask

    // Result side: check the beat taken at this edge, then choose the next ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready)
                sb.check_deletable(o_deletable);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("thinning_deletable_voxel_test_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        tdvt_pkg::t_nbh m1_seed, m5_seed, nbh;
        logic [2:0]     dir;
        int             k;
        sb = new();
        idle_on = 1'b1;
        quiet_cycles = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_neighborhood <= '0;
        i_mode <= tdvt_pkg::MODE_UP;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        m1_seed = vox_bit(1, 0, 1) | vox_bit(0, 0, 0);
        m5_seed = vox_bit(1, 0, 0) | vox_bit(0, 1, 0);

        drive_voxel('0, tdvt_pkg::MODE_UP);
        drive_voxel('1, tdvt_pkg::MODE_UP);
        drive_voxel(vox_bit(1, 0, 1), tdvt_pkg::MODE_UP);
        drive_voxel(m1_seed, tdvt_pkg::MODE_UP);
        // The centre voxel must not change the answer.
        drive_voxel(m1_seed | vox_bit(1, 1, 1), tdvt_pkg::MODE_UP);
        drive_voxel(vox_bit(1, 0, 2) | vox_bit(0, 0, 1), tdvt_pkg::MODE_UP);
        drive_voxel(m5_seed, tdvt_pkg::MODE_UP);
        drive_voxel(vox_bit(1, 0, 1) | vox_bit(0, 2, 0) | vox_bit(0, 1, 0),
                    tdvt_pkg::MODE_UP);
        drive_voxel(vox_bit(1, 0, 1) | vox_bit(0, 1, 1) | vox_bit(0, 2, 0) |
                    vox_bit(0, 2, 2), tdvt_pkg::MODE_UP);
        drive_voxel(vox_bit(1, 0, 1) | vox_bit(1, 1, 2) | vox_bit(0, 1, 1) |
                    vox_bit(0, 2, 0) | vox_bit(0, 2, 1) | vox_bit(0, 2, 2) |
                    vox_bit(2, 2, 2) | vox_bit(1, 2, 2), tdvt_pkg::MODE_UP);
        // Known matches turned into every direction code, the unused codes too.
        for (k = 0; k < 8; k++) begin
            dir = 3'(k);
            drive_voxel(sb.reorient(m1_seed, undo_dir(dir)), dir);
            drive_voxel(sb.reorient(m5_seed, undo_dir(dir)), dir);
        end

        for (k = 0; k < RandItems; k++) begin
            if (k == RandItems - CalmItems)
                idle_on = 1'b0;
            dir = pick_dir();
            if ($urandom_range(0, 4) == 0)
                nbh = tdvt_pkg::t_nbh'($urandom);
            else
                nbh = sb.reorient(shaped_voxel(), undo_dir(dir));
            drive_voxel(nbh, dir);
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("thinning_deletable_voxel_test_unit: match");
        else
            $display("thinning_deletable_voxel_test_unit: mismatch");
        $finish;
    end

endmodule
